// ===== rtl/core/hfs_pkg.sv =====
// Shared types, constants and helpers for the hex float text parser.
`timescale 1ns / 1ps
package hfs_pkg;

  localparam int COUNT_WIDTH = 24;   // saturating counter width
  localparam int MANT_W      = 60;   // 15 kept hex digits
  localparam int EXPV_W      = 30;   // decimal exponent value
  localparam int END_W       = 25;   // signed end offset
  localparam int EW          = 37;   // exponent arithmetic width
  localparam int KEEP_DIGITS = 15;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = '1;
  localparam logic [EXPV_W-1:0]      EXP_LIMIT   = EXPV_W'(100000000);
  localparam logic signed [31:0]     ADJ_FLOOR   = 32'sh80000004;
  localparam logic [32:0]            END_SAT     = 33'd16777215;
  localparam logic signed [EW-1:0]   EXP_BASE    = EW'(1084);
  localparam logic signed [EW-1:0]   EXP_TOP     = EW'(2045);
  localparam logic signed [EW-1:0]   EXP_BOTTOM  = -EW'(53);
  localparam logic [63:0]            INF_BITS    = 64'h7FF0000000000000;
  localparam logic [63:0]            MAXF_BITS   = 64'h7FEFFFFFFFFFFFFF;

  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_LOW_P = 8'h70;
  localparam logic [7:0] CH_UP_P  = 8'h50;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef enum logic [2:0] {PH_IDLE, PH_MANT, PH_MARK, PH_SIGN, PH_EDIG} phase_t;
  typedef enum logic [1:0] {RM_NEAREST, RM_DOWN, RM_UP, RM_ZERO} rmode_t;

  typedef struct packed {
    logic                     sign;
    logic [MANT_W-1:0]        mant;
    logic [COUNT_WIDTH-1:0]   digits;
    logic [COUNT_WIDTH-1:0]   before_point;
    logic                     point;
    logic signed [31:0]       exp_adjust;
    logic                     exp_neg;
    logic [EXPV_W-1:0]        exp_val;
    logic                     use_exp;
    logic signed [END_W-1:0]  end_offset;
  } job_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ===== rtl/core/hfs_front.sv =====
// Character parser: tracks digits, point and exponent, emits a job per number.
`timescale 1ns / 1ps
module hfs_front import hfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       acc,
  input  logic [7:0] ch,
  input  logic       negative,
  input  logic       first,
  output logic       push,
  output job_t       job
);

  phase_t                 phase, phase_next;
  logic [MANT_W-1:0]      mant, mant_next;
  logic [COUNT_WIDTH-1:0] digits, digits_next, bpoint, bpoint_next;
  logic [COUNT_WIDTH-1:0] lzc, lzc_next, chars, chars_next, mark, mark_next;
  logic                   point, point_next, eneg, eneg_next, sign, sign_next;
  logic signed [31:0]     adj, adj_next;
  logic [EXPV_W-1:0]      ev, ev_next;

  phase_t                 c_phase;
  logic [MANT_W-1:0]      c_mant;
  logic [COUNT_WIDTH-1:0] c_digits, c_bpoint, c_lzc, c_chars, c_mark, dinc, fin_end;
  logic                   c_point, c_eneg, c_sign, fin, use_exp, is_hex, is_dec;
  logic signed [31:0]     c_adj;
  logic [EXPV_W-1:0]      c_ev;
  logic [3:0]             hex, dec;
  logic [32:0]            end_ext;

  always_comb begin
    is_hex = 1'b1;
    hex    = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) hex = 4'(ch - 8'h30);
    else if (ch >= 8'h61 && ch <= 8'h66) hex = 4'(ch - 8'h57);
    else if (ch >= 8'h41 && ch <= 8'h46) hex = 4'(ch - 8'h37);
    else is_hex = 1'b0;
    is_dec = (ch >= 8'h30 && ch <= 8'h39);
    dec    = 4'(ch - CH_ZERO);
  end

  always_comb begin
    // a first character restarts the number
    c_phase = phase;  c_mant = mant;   c_digits = digits; c_bpoint = bpoint;
    c_lzc = lzc;      c_chars = chars; c_mark = mark;     c_point = point;
    c_eneg = eneg;    c_sign = sign;   c_adj = adj;       c_ev = ev;
    if (first) begin
      c_phase = PH_MANT; c_mant = '0; c_digits = '0; c_bpoint = '0;
      c_lzc = '0; c_chars = '0; c_mark = '0; c_point = 1'b0;
      c_eneg = 1'b0; c_sign = negative; c_adj = '0; c_ev = '0;
    end

    phase_next = c_phase; mant_next = c_mant; digits_next = c_digits;
    bpoint_next = c_bpoint; lzc_next = c_lzc; mark_next = c_mark;
    point_next = c_point; eneg_next = c_eneg; sign_next = c_sign;
    adj_next = c_adj; ev_next = c_ev;
    fin = 1'b0; use_exp = 1'b0; fin_end = c_chars;
    dinc = sat_inc(c_digits);

    case (c_phase)
      PH_MANT: begin
        if (is_hex) begin
          if (c_digits == '0 && hex == 4'd0) begin
            lzc_next = sat_inc(c_lzc);
            if (c_point && c_adj > ADJ_FLOOR) adj_next = c_adj - 32'sd4;
          end else begin
            digits_next = dinc;
            if (dinc < COUNT_WIDTH'(16)) mant_next = {c_mant[MANT_W-5:0], hex};
            else if (hex != 4'd0) mant_next[0] = 1'b1;
          end
        end else if (ch == CH_POINT) begin
          if (c_point) fin = 1'b1;
          else begin
            point_next  = 1'b1;
            bpoint_next = c_digits;
          end
        end else if (ch == CH_LOW_P || ch == CH_UP_P) begin
          mark_next  = c_chars;
          eneg_next  = 1'b0;
          ev_next    = '0;
          phase_next = PH_MARK;
        end else begin
          fin = 1'b1;
        end
      end
      PH_MARK, PH_SIGN: begin
        if (is_dec) begin
          ev_next    = EXPV_W'(dec);
          phase_next = PH_EDIG;
        end else if (c_phase == PH_MARK && (ch == CH_MINUS || ch == CH_PLUS)) begin
          eneg_next  = (ch == CH_MINUS);
          phase_next = PH_SIGN;
        end else begin
          fin     = 1'b1;
          fin_end = c_mark;
        end
      end
      PH_EDIG: begin
        if (is_dec) begin
          if (c_ev < EXP_LIMIT)
            ev_next = (c_ev << 3) + (c_ev << 1) + EXPV_W'(dec);
        end else begin
          fin     = 1'b1;
          use_exp = 1'b1;
        end
      end
      default: ;
    endcase

    chars_next = c_chars;
    if (!fin && c_phase != PH_IDLE) chars_next = sat_inc(c_chars);
    if (fin) phase_next = PH_IDLE;
  end

  always_comb begin
    end_ext          = 33'(fin_end);
    push             = acc && fin;
    job.sign         = c_sign;
    job.mant         = c_mant;
    job.digits       = c_digits;
    job.before_point = c_bpoint;
    job.point        = c_point;
    job.exp_adjust   = c_adj;
    job.exp_neg      = c_eneg;
    job.exp_val      = c_ev;
    job.use_exp      = use_exp;
    if (c_digits == '0 && c_lzc == '0) job.end_offset = '1;
    else if (end_ext > END_SAT)        job.end_offset = END_W'(END_SAT);
    else                               job.end_offset = END_W'(end_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; mant <= '0; digits <= '0; bpoint <= '0; lzc <= '0;
      chars <= '0; mark <= '0; point <= 1'b0; eneg <= 1'b0; sign <= 1'b0;
      adj <= '0; ev <= '0;
    end else if (acc) begin
      phase <= phase_next; mant <= mant_next; digits <= digits_next;
      bpoint <= bpoint_next; lzc <= lzc_next; chars <= chars_next;
      mark <= mark_next; point <= point_next; eneg <= eneg_next;
      sign <= sign_next; adj <= adj_next; ev <= ev_next;
    end
  end

endmodule

// ===== rtl/core/hfs_queue.sv =====
// Two-entry job queue between parser and conversion pipeline.
`timescale 1ns / 1ps
module hfs_queue import hfs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic empty
);

  job_t       mem [2];
  logic       wptr, rptr;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/core/hfs_back.sv =====
// Conversion pipeline: normalize, range check, round and pack the double.
`timescale 1ns / 1ps
module hfs_back import hfs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  input  logic              q_empty,
  input  job_t              q_job,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       out_bits,
  output logic [END_W-1:0]  out_end,
  output logic              out_rerr
);

  function automatic logic [4:0] clz16(input logic [15:0] v);
    logic [4:0] n;
    logic       hit;
    n = 5'd16; hit = 1'b0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i] && !hit) begin
        n = 5'(15 - i);
        hit = 1'b1;
      end
    end
    clz16 = n;
  endfunction

  rmode_t rmode;
  logic   en;

  // stage 1
  logic                    s1_v, s1_sign, s1_nz;
  logic [63:0]             s1_m;
  logic signed [EW-1:0]    s1_a, s1_b;
  logic [4:0]              s1_clz [4];
  logic [3:0]              s1_cnz;
  logic [END_W-1:0]        s1_end;
  // stage 2
  logic                    s2_v, s2_sign, s2_nz;
  logic [63:0]             s2_m;
  logic signed [EW-1:0]    s2_e;
  logic [6:0]              s2_lz;
  logic [END_W-1:0]        s2_end;
  // stage 3
  logic                    s3_v, s3_sign, s3_nz, s3_ovf, s3_unf, s3_away, s3_trunc;
  logic [63:0]             s3_m, s3_inc;
  logic [10:0]             s3_ef;
  logic [5:0]              s3_d;
  logic [END_W-1:0]        s3_end;
  // stage 4
  logic                    s4_v, s4_sign, s4_nz, s4_ovf, s4_unf, s4_away, s4_trunc;
  logic [63:0]             s4_m;
  logic [10:0]             s4_ef;
  logic [5:0]              s4_d;
  logic [END_W-1:0]        s4_end;

  // stage 1 combinational
  logic [63:0]             m64;
  logic [COUNT_WIDTH-1:0]  kept, pt;
  logic signed [EW-1:0]    ptx, keptx, evx, adjx;
  // stage 2 combinational
  logic [6:0]              clz;
  // stage 3 combinational
  logic                    is_away, is_trunc, rnd_en;
  logic [5:0]              dd;
  logic signed [EW-1:0]    neg_e;
  logic [63:0]             half, inc;
  // output combinational
  logic [63:0]             bits_next;
  logic [6:0]              rsh;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) rmode <= RM_NEAREST;
    else if (cfg_we) rmode <= rmode_t'(cfg_wdata);
  end

  always_comb begin
    m64   = {4'd0, q_job.mant};
    kept  = (q_job.digits > COUNT_WIDTH'(KEEP_DIGITS)) ? COUNT_WIDTH'(KEEP_DIGITS)
                                                       : q_job.digits;
    pt    = q_job.point ? q_job.before_point : q_job.digits;
    ptx   = EW'(pt);
    keptx = EW'(kept);
    evx   = EW'(q_job.exp_val);
    adjx  = EW'(q_job.exp_adjust);
  end

  always_comb begin
    if (s1_cnz[3])      clz = 7'(s1_clz[3]);
    else if (s1_cnz[2]) clz = 7'd16 + 7'(s1_clz[2]);
    else if (s1_cnz[1]) clz = 7'd32 + 7'(s1_clz[1]);
    else                clz = 7'd48 + 7'(s1_clz[0]);
  end

  always_comb begin
    case (rmode)
      RM_DOWN: begin is_away = s2_sign;  is_trunc = !s2_sign; end
      RM_UP:   begin is_away = !s2_sign; is_trunc = s2_sign;  end
      RM_ZERO: begin is_away = 1'b0;     is_trunc = 1'b1;     end
      default: begin is_away = 1'b0;     is_trunc = 1'b0;     end
    endcase
    neg_e  = -s2_e;
    dd     = (s2_e < 0) ? 6'(neg_e) : 6'd0;
    rnd_en = s2_lz < (7'd10 + 7'(dd));
    half   = 64'h200 << dd;
    inc    = 64'd0;
    // nearest-even: the mask covers the bits below half and the kept LSB
    if (rnd_en) begin
      if (is_away) inc = (64'h400 << dd) - 64'd1;
      else if (!is_trunc && ((s2_m & ((64'h600 << dd) - 64'd1)) != 64'd0)) inc = half;
    end
  end

  always_comb begin
    rsh       = 7'd10 + 7'(s4_d);
    bits_next = {s4_sign, 63'd0};
    if (!s4_nz)       bits_next = {s4_sign, 63'd0};
    else if (s4_ovf)  bits_next = {s4_sign, 63'd0} | (s4_trunc ? MAXF_BITS : INF_BITS);
    else if (s4_unf)  bits_next = {s4_sign, 62'd0, s4_away};
    else              bits_next = {s4_sign, 63'd0} + {1'b0, s4_ef, 52'd0} + (s4_m >> rsh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0; s4_v <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      s1_v <= !q_empty; s2_v <= s1_v; s3_v <= s2_v; s4_v <= s3_v; out_valid <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // leading-zero search per 16-bit chunk, exponent partial sums
      s1_sign <= q_job.sign;
      s1_nz   <= (q_job.mant != '0);
      s1_m    <= m64;
      s1_end  <= q_job.end_offset;
      s1_a    <= adjx + ((ptx - keptx) <<< 2);
      if (!q_job.use_exp)     s1_b <= EXP_BASE;
      else if (q_job.exp_neg) s1_b <= EXP_BASE - evx;
      else                    s1_b <= EXP_BASE + evx;
      for (int k = 0; k < 4; k++) begin
        s1_clz[k] <= clz16(m64[16*k +: 16]);
        s1_cnz[k] <= (m64[16*k +: 16] != 16'd0);
      end
      // normalize
      s2_sign <= s1_sign; s2_nz <= s1_nz; s2_end <= s1_end;
      s2_lz   <= clz - 7'd1;
      s2_e    <= s1_a + s1_b - EW'(clz - 7'd1);
      s2_m    <= s1_m << (clz - 7'd1);
      // range check, rounding increment
      s3_sign <= s2_sign; s3_nz <= s2_nz; s3_end <= s2_end; s3_m <= s2_m;
      s3_ovf  <= s2_e > EXP_TOP;
      s3_unf  <= s2_e < EXP_BOTTOM;
      s3_away <= is_away; s3_trunc <= is_trunc;
      s3_d    <= dd;
      s3_ef   <= (s2_e < 0) ? 11'd0 : 11'(s2_e);
      s3_inc  <= inc;
      // round
      s4_sign <= s3_sign; s4_nz <= s3_nz; s4_end <= s3_end;
      s4_ovf  <= s3_ovf;  s4_unf <= s3_unf; s4_away <= s3_away; s4_trunc <= s3_trunc;
      s4_d    <= s3_d;    s4_ef  <= s3_ef;
      s4_m    <= s3_m + s3_inc;
      // pack
      out_bits <= bits_next;
      out_end  <= s4_end;
      out_rerr <= s4_nz && (s4_ovf || s4_unf);
    end
  end

endmodule

// ===== rtl/core/hex_float_string_to_double_core.sv =====
// Top level: hex float text stream in, IEEE double results out.
`timescale 1ns / 1ps
// Throughput: one character per cycle while the queue is not full; results at one per cycle while m_tready is high.
// Path: the terminating character's result reaches m_tvalid through the queue write on
//   its transaction's edge, the four pipeline stages and the output register; m_tready low holds it.
// Reset (rst, synchronous): parser idle, queue and pipeline empty,
//   rounding mode nearest-even.
module hex_float_string_to_double_core import hfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] ch, [8] negative, rest zero
  input  logic        s_tuser,   // first
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [63:0] value_bits, [88:64] end_offset, rest zero
  output logic        m_tuser,   // range_error
  // rounding mode register
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  job_t               f_job, q_job;
  logic               f_push, q_full, q_empty, q_pop, s_acc;
  logic [63:0]        value_bits;
  logic [END_W-1:0]   end_offset;

  // Front stalls only when the queue is full; every transaction is a
  // character, whether or not it ends a number.
  assign s_tready = !q_full;
  assign s_acc    = s_tvalid && s_tready;

  hfs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .acc      (s_acc),
    .ch       (s_tdata[7:0]),
    .negative (s_tdata[8]),
    .first    (s_tuser),
    .push     (f_push),
    .job      (f_job)
  );

  hfs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (f_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_job),
    .empty (q_empty)
  );

  // Back end advances as a whole whenever the output register is free.
  hfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_bits  (value_bits),
    .out_end   (end_offset),
    .out_rerr  (m_tuser)
  );

  assign m_tdata = {7'd0, end_offset, value_bits};

endmodule
